/* hdl/gsppm_pkg.sv */
`timescale 1ns / 1ps
package gsppm_pkg;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = 17;
    localparam int PPM_W      = 22;
    localparam int REG_W      = 16;
    localparam int RATIO_W    = 12;
    localparam int NUM_W      = 40;
    localparam int DEN_W      = 28;
    localparam int EMA_W      = 27;
    localparam int EMA_SHIFT  = 28;

    localparam logic [SAMPLE_W-1:0] AVG_LOW      = 12'd100;
    localparam logic [SAMPLE_W-1:0] AVG_HIGH     = 12'd3800;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE   = 12'd4095;
    localparam logic [REG_W-1:0]    DEFAULT_RO   = 16'd2560;
    localparam logic [REG_W-1:0]    RL_RESET     = 16'd2560;
    localparam logic [RATIO_W-1:0]  RATIO_MIN    = 12'd128;
    localparam logic [RATIO_W-1:0]  RATIO_MAX    = 12'd2048;
    localparam logic [PPM_W-1:0]    PPM_MIN      = 22'd89600;
    localparam logic [PPM_W-1:0]    PPM_MAX      = 22'd2559744;
    localparam logic [PPM_W-1:0]    PPM_RESET    = 22'd102400;
    // ceil(2^28 / 10), exact divide by ten for sums below 2^26
    localparam logic [24:0]         EMA_RECIP    = 25'd26843546;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;

    localparam logic [0:0] CFG_RO = 1'b0;
    localparam logic [0:0] CFG_RL = 1'b1;

    typedef struct packed {
        logic accum;
        logic clear;
        logic div_avg_start;
        logic ratio_prep;
        logic div_ratio_start;
        logic curve;
        logic ema_start;
        logic commit;
    } gsppm_cmd_t;

    typedef struct packed {
        logic       div_done;
        logic       ema_done;
        logic       few;
        logic       out_range;
    } gsppm_stat_t;

    function automatic logic [PPM_W-1:0] curve_node(input logic [2:0] i);
        logic [PPM_W-1:0] v;
        case (i)
            3'd0:    v = 22'd203471;
            3'd1:    v = 22'd172029;
            3'd2:    v = 22'd146847;
            3'd3:    v = 22'd126428;
            3'd4:    v = 22'd109688;
            3'd5:    v = 22'd95826;
            default: v = 22'd84244;
        endcase
        return v;
    endfunction
endpackage

/* hdl/gas_sensor_ppm_estimator_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  Ports                      Contents
// s_axis    in   s_tvalid/s_tready/s_tdata  sample[11:0]; s_tuser = sample_ok
// m_axis    out  m_tvalid/m_tready/m_tdata  ppm_smoothed_q8, raw_average, status
// cfg       in   cfg_we/cfg_index/cfg_data  0 clean-air Ro, 1 load RL
// One item per cycle within a window; the input is held off while it closes.
// Last item to result register: with too few ok items no divide runs; with the
// average out of range only the average divide; else the full path (two 40-step divides, curve, EMA).
// Reset aresetn: synchronous, clears window, smoothing state 400 ppm.
// One output register holds a result; meanwhile the next window still collects, then waits to emit.
module gas_sensor_ppm_estimator_top #(
    parameter int WINDOW_SAMPLES = 20,
    parameter int MIN_OK_SAMPLES = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[11:0]
    input  logic        s_tuser,   // sample_ok
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // ppm_smoothed_q8[21:0], raw_average[33:22], status[35:34]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import gsppm_pkg::*;
    logic [REG_W-1:0] ro_reg, rl_reg;
    gsppm_cmd_t  cmd;
    gsppm_stat_t stat;
    logic in_ready, in_fire, emit, avg_zero, out_free;
    logic [1:0] est;
    logic [PPM_W-1:0] ppm;
    logic [SAMPLE_W-1:0] avg;
    logic mv_reg;
    logic [39:0] md_reg;

    assign in_fire  = s_tvalid && in_ready;
    assign s_tready = in_ready;
    assign out_free = !mv_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ro_reg <= '0; rl_reg <= RL_RESET; mv_reg <= 1'b0;
        end else begin
            if (cfg_we && cfg_index == CFG_RO) ro_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_RL) rl_reg <= cfg_data;
            if (emit) mv_reg <= 1'b1;
            else if (m_tready) mv_reg <= 1'b0;
        end
        if (emit) md_reg <= {4'd0, est, avg_zero ? 12'd0 : avg, ppm};
    end

    gsppm_ctrl #(.WINDOW(WINDOW_SAMPLES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire), .out_free(out_free),
        .stat(stat), .cmd(cmd), .in_ready(in_ready), .emit(emit),
        .emit_status(est), .emit_avg_zero(avg_zero)
    );

    gsppm_datapath #(.MIN_OK(MIN_OK_SAMPLES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .sample(s_tdata[SAMPLE_W-1:0]), .sample_ok(s_tuser),
        .ro_cfg(ro_reg), .rl_cfg(rl_reg), .ppm_out(ppm), .avg_out(avg)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
endmodule

/* hdl/gsppm_div.sv */
`timescale 1ns / 1ps
module gsppm_div #(
    parameter int NW = 40,
    parameter int DW = 28
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next, done_reg, done_next;
    logic [DW:0]   trial;

    always_comb begin
        q_next = q_reg; r_next = r_reg; d_next = d_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        if (start) begin
            q_next = num; r_next = '0; d_next = den;
            cnt_next = CW'(NW); busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, d_reg}) begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[NW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
        q_reg <= q_next; r_reg <= r_next; d_reg <= d_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule

/* hdl/gsppm_datapath.sv */
`timescale 1ns / 1ps
module gsppm_datapath #(
    parameter int MIN_OK = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  gsppm_pkg::gsppm_cmd_t           cmd,
    output gsppm_pkg::gsppm_stat_t          stat,
    input  logic [gsppm_pkg::SAMPLE_W-1:0]  sample,
    input  logic                            sample_ok,
    input  logic [gsppm_pkg::REG_W-1:0]     ro_cfg,
    input  logic [gsppm_pkg::REG_W-1:0]     rl_cfg,
    output logic [gsppm_pkg::PPM_W-1:0]     ppm_out,
    output logic [gsppm_pkg::SAMPLE_W-1:0]  avg_out
);
    import gsppm_pkg::*;

    logic [SUM_W-1:0]    sum_reg;
    logic [4:0]          okc_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [27:0]         prod_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic [PPM_W-1:0]    ppm_reg, sm_reg;
    logic [NUM_W-1:0]    dnum;
    logic [DEN_W-1:0]    dden;
    logic                dstart, ddone;
    logic [NUM_W-1:0]    dq;
    logic                ratio_phase_reg;
    logic [REG_W-1:0]    ro_eff;
    logic [RATIO_W-1:0]  off;
    logic [2:0]          seg;
    logic [PPM_W-1:0]    hi, lo, cv;
    logic [PPM_W+2:0]    dprod;
    logic [EMA_W-1:0]    ema_sum;
    logic                ema_busy_reg;
    logic [EMA_W-1:0]    ema_sum_reg;
    logic [EMA_W+24:0]   ema_prod;
    logic [PPM_W-1:0]    ema_q_reg;
    logic                ema_stage_reg, ema_done_reg;

    assign ro_eff = (ro_cfg == '0) ? DEFAULT_RO : ro_cfg;
    assign dstart = cmd.div_avg_start | cmd.div_ratio_start;

    always_comb begin
        if (cmd.div_ratio_start) begin
            dnum = {prod_reg, 8'd0, 4'd0} >> 4;
            dden = DEN_W'(avg_reg) * DEN_W'(ro_eff);
        end else begin
            dnum = NUM_W'(sum_reg);
            dden = DEN_W'(okc_reg);
        end
    end

    assign ema_sum = EMA_W'(ppm_reg) * EMA_W'(3) + EMA_W'(sm_reg) * EMA_W'(7) + EMA_W'(5);
    assign ema_prod = (EMA_W+25)'(ema_sum_reg) * (EMA_W+25)'(EMA_RECIP);

    gsppm_div #(.NW(NUM_W), .DW(DEN_W)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart),
        .num(dnum), .den(dden), .done(ddone), .quo(dq)
    );

    always_comb begin
        off = (ratio_reg < RATIO_MIN) ? '0 : ratio_reg - RATIO_MIN;
        seg = (off[RATIO_W-1:3] >= 9'd6) ? 3'd6 : off[5:3];
        hi  = curve_node(seg);
        lo  = curve_node((seg == 3'd6) ? 3'd6 : seg + 3'd1);
        dprod = (PPM_W+3)'(hi - lo) * (PPM_W+3)'(off[2:0]);
        cv  = (seg == 3'd6) ? hi : hi - PPM_W'(dprod >> 3);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0; okc_reg <= '0; sm_reg <= PPM_RESET;
            avg_reg <= '0; ratio_phase_reg <= 1'b0; ema_busy_reg <= 1'b0;
            ema_stage_reg <= 1'b0; ema_done_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                sum_reg <= '0; okc_reg <= '0;
            end else if (cmd.accum && sample_ok) begin
                sum_reg <= sum_reg + SUM_W'(sample);
                okc_reg <= okc_reg + 5'd1;
            end
            if (cmd.div_avg_start) begin
                avg_reg <= '0;
                ratio_phase_reg <= 1'b0; ema_busy_reg <= 1'b0;
            end
            if (cmd.div_ratio_start) ratio_phase_reg <= 1'b1;
            if (cmd.ema_start) begin
                ratio_phase_reg <= 1'b0; ema_busy_reg <= 1'b1;
            end
            ema_stage_reg <= cmd.ema_start;
            ema_done_reg  <= ema_stage_reg;
            if (ddone && !ratio_phase_reg && !ema_busy_reg)
                avg_reg <= dq[SAMPLE_W-1:0];
            if (ddone && ratio_phase_reg)
                ratio_reg <= (dq < NUM_W'(RATIO_MIN)) ? RATIO_MIN :
                             (dq > NUM_W'(RATIO_MAX)) ? RATIO_MAX : dq[RATIO_W-1:0];
            if (cmd.commit && ema_busy_reg)
                sm_reg <= ema_q_reg;
            if (cmd.commit) ema_busy_reg <= 1'b0;
        end
        if (cmd.ratio_prep)
            prod_reg <= 28'(rl_cfg) * 28'(FULL_SCALE - avg_reg);
        if (cmd.curve)
            ppm_reg <= (cv < PPM_MIN) ? PPM_MIN : (cv > PPM_MAX) ? PPM_MAX : cv;
        if (cmd.ema_start)
            ema_sum_reg <= ema_sum;
        if (ema_stage_reg)
            ema_q_reg <= PPM_W'(ema_prod >> EMA_SHIFT);
    end

    assign stat.div_done  = ddone;
    assign stat.ema_done  = ema_done_reg;
    assign stat.few       = (okc_reg < 5'(MIN_OK)) || (okc_reg == '0);
    assign stat.out_range = (avg_reg < AVG_LOW) || (avg_reg > AVG_HIGH);
    assign ppm_out = (cmd.commit && ema_busy_reg) ? ema_q_reg : sm_reg;
    assign avg_out = avg_reg;
endmodule

/* hdl/gsppm_ctrl.sv */
`timescale 1ns / 1ps
module gsppm_ctrl #(
    parameter int WINDOW = 20
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_fire,
    input  logic                    out_free,
    input  gsppm_pkg::gsppm_stat_t  stat,
    output gsppm_pkg::gsppm_cmd_t   cmd,
    output logic                    in_ready,
    output logic                    emit,
    output logic [1:0]              emit_status,
    output logic                    emit_avg_zero
);
    import gsppm_pkg::*;
    typedef enum logic [2:0] {S_COLLECT, S_AVG, S_RATIO, S_DIVR, S_CURVE,
                              S_EMA, S_EMIT} state_t;
    state_t     state_reg, state_next;
    logic [4:0] pos_reg, pos_next;
    logic [1:0] st_reg, st_next;

    always_comb begin
        state_next = state_reg; pos_next = pos_reg; st_next = st_reg;
        cmd = '0; emit = 1'b0;
        in_ready = (state_reg == S_COLLECT);
        case (state_reg)
            S_COLLECT: begin
                cmd.accum = in_fire;
                if (in_fire) begin
                    pos_next = pos_reg + 5'd1;
                    if (pos_reg + 5'd1 >= 5'(WINDOW)) begin
                        pos_next = '0;
                        state_next = S_AVG;
                    end
                end
            end
            S_AVG: begin
                if (stat.few) begin
                    st_next = ST_FEW; state_next = S_EMIT;
                end else begin
                    cmd.div_avg_start = 1'b1; state_next = S_RATIO;
                end
            end
            S_RATIO: if (stat.div_done) state_next = S_DIVR;
            S_DIVR: begin
                if (stat.out_range) begin
                    st_next = ST_RANGE; state_next = S_EMIT;
                end else begin
                    cmd.ratio_prep = 1'b1; state_next = S_CURVE;
                end
            end
            S_CURVE: begin
                if (pos_reg == '0) begin
                    cmd.div_ratio_start = 1'b1; pos_next = 5'd1;
                end else if (stat.div_done && pos_reg == 5'd1) begin
                    pos_next = 5'd2;
                end else if (pos_reg == 5'd2) begin
                    cmd.curve = 1'b1; pos_next = 5'd3;
                end else if (pos_reg == 5'd3) begin
                    cmd.ema_start = 1'b1; pos_next = '0;
                    st_next = ST_OK; state_next = S_EMA;
                end
            end
            S_EMA: if (stat.ema_done) state_next = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    emit = 1'b1; cmd.commit = 1'b1; cmd.clear = 1'b1;
                    state_next = S_COLLECT;
                end
            end
            default: state_next = S_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_COLLECT; pos_reg <= '0; st_reg <= ST_OK;
        end else begin
            state_reg <= state_next; pos_reg <= pos_next; st_reg <= st_next;
        end
    end

    assign emit_status   = st_reg;
    assign emit_avg_zero = (st_reg == ST_FEW);
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import gsppm_pkg::*;

    localparam int WIN     = 20;
    localparam int MIN_OK  = 5;
    localparam int LIMIT   = 2000000;
    localparam int SETTLE  = 400;

    typedef struct packed {
        logic [1:0]        status;
        logic [SAMPLE_W-1:0] avg;
        logic [PPM_W-1:0]  ppm;
    } window_result_t;

    class window_scoreboard;
        logic [REG_W-1:0] ro_reg;
        logic [REG_W-1:0] rl_reg;
        logic [SUM_W-1:0] sum;
        logic [4:0]       pos;
        logic [4:0]       n_ok;
        logic [PPM_W-1:0] smooth;
        window_result_t   pending[$];
        int               errors;

        function new();
            ro_reg = '0;
            rl_reg = RL_RESET;
            sum    = '0;
            pos    = '0;
            n_ok   = '0;
            smooth = PPM_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [REG_W-1:0] v);
            if (idx == CFG_RO) ro_reg = v;
            else rl_reg = v;
        endfunction

        function logic [PPM_W-1:0] ppm_from_ratio(logic [63:0] r);
            logic [63:0] off, seg, frac, hi, lo, tbl[7];
            tbl = '{203471, 172029, 146847, 126428, 109688, 95826, 84244};
            off = r - 128;
            seg = off >> 3;
            if (seg >= 6) return PPM_W'(tbl[6]);
            frac = off & 7;
            hi = tbl[seg];
            lo = tbl[seg + 1];
            return PPM_W'(hi - (((hi - lo) * frac) >> 3));
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s, logic ok);
            window_result_t res;
            logic [63:0] avg, ro, num, den, r, ppm;
            if (ok) begin
                sum  = sum + SUM_W'(s);
                n_ok = n_ok + 5'd1;
            end
            pos = pos + 5'd1;
            if (pos < WIN) return;
            avg = 0;
            if (n_ok < MIN_OK) begin
                res.status = ST_FEW;
            end else begin
                avg = sum / n_ok;
                if (avg < AVG_LOW || avg > AVG_HIGH) begin
                    res.status = ST_RANGE;
                end else begin
                    ro  = (ro_reg != 0) ? ro_reg : DEFAULT_RO;
                    num = 64'(rl_reg) * (4095 - avg) * 256;
                    den = avg * ro;
                    r   = num / den;
                    if (r < RATIO_MIN) r = RATIO_MIN;
                    if (r > RATIO_MAX) r = RATIO_MAX;
                    ppm = ppm_from_ratio(r);
                    if (ppm < PPM_MIN) ppm = PPM_MIN;
                    if (ppm > PPM_MAX) ppm = PPM_MAX;
                    smooth = PPM_W'((3 * ppm + 7 * 64'(smooth) + 5) / 10);
                    res.status = ST_OK;
                end
            end
            res.ppm = smooth;
            res.avg = avg[SAMPLE_W-1:0];
            pending.push_back(res);
            sum  = '0;
            pos  = '0;
            n_ok = '0;
        endfunction

        task check_result(logic [39:0] d);
            window_result_t got, want;
            got = d[35:0];
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", d));
                return;
            end
            want = pending.pop_front();
            if (got.ppm != want.ppm)
                report_mismatch($sformatf("ppm %0d exp %0d", got.ppm, want.ppm));
            if (got.avg != want.avg)
                report_mismatch($sformatf("avg %0d exp %0d", got.avg, want.avg));
            if (got.status != want.status)
                report_mismatch($sformatf("status %0d exp %0d", got.status, want.status));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;

    window_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_hold = 1'b0;
    int  cycles = 0;

    always #2 aclk = ~aclk;

    gas_sensor_ppm_estimator_top #(.WINDOW_SAMPLES(WIN), .MIN_OK_SAMPLES(MIN_OK)) i_dut (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_index, .cfg_data
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(negedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);

    task automatic send_sample(logic [SAMPLE_W-1:0] s, logic ok);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, s};
        s_tuser  <= ok;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(s, ok);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_cfg(logic idx, logic [15:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.write_reg(idx, v);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic send_window(int lo, int hi, int bad_pct);
        for (int k = 0; k < WIN; k++)
            send_sample(SAMPLE_W'($urandom_range(hi, lo)), $urandom_range(99) >= bad_pct);
    endtask

    task automatic random_phase(int windows);
        int kind;
        for (int w = 0; w < windows; w++) begin
            kind = $urandom_range(9);
            if (kind < 6) send_window($urandom_range(1500, 100), $urandom_range(3800, 1600), 10);
            else if (kind == 6) send_window(0, 4095, 85);
            else if (kind == 7) send_window(0, 4095, 0);
            else send_window($urandom_range(3900, 3700), 4095, 30);
        end
    endtask

    initial begin
        logic [15:0] ro_set[4];
        logic [15:0] rl_set[4];
        ro_set = '{16'd0, 16'd65535, 16'd1, 16'd2560};
        rl_set = '{16'd65535, 16'd1, 16'd0, 16'd2560};
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed windows at reset settings
        for (int k = 0; k < WIN; k++) send_sample(12'd2000, 1'b1);
        for (int k = 0; k < WIN; k++) send_sample(12'hFFF, k < 4);
        for (int k = 0; k < WIN; k++) send_sample(12'd0, 1'b1);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_cfg(CFG_RO, ro_set[p]);
            write_cfg(CFG_RL, rl_set[p]);
            for (int k = 0; k < WIN; k++) send_sample(k[0] ? 12'd100 : 12'd3800, 1'b1);
            drain();
        end

        tx_idle_pct = 14; rx_idle_pct = 84;
        random_phase(33);
        drain();
        write_cfg(CFG_RO, 16'($urandom));
        write_cfg(CFG_RL, 16'($urandom));
        tx_idle_pct = 84; rx_idle_pct = 14;
        random_phase(33);
        drain();
        write_cfg(CFG_RO, 16'd2560);
        write_cfg(CFG_RL, 16'($urandom_range(8000, 500)));
        tx_idle_pct = 0; rx_idle_pct = 0;
        fork
            begin
                rx_hold = 1'b1;
                repeat (3000) @(negedge aclk);
                rx_hold = 1'b0;
            end
            random_phase(34);
        join
        drain();

        if (sb.errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
